@@ sv/hpwg_pkg.sv @@
// ============================================================================
// hpwg_pkg
// Shared types and codes of the heartbeat pulse generator: datapath
// operation codes, curve segment codes and the control/status bundles.
// ============================================================================
package hpwg_pkg;

    localparam int OP_W  = 5;
    localparam int SEG_W = 3;

    // datapath operations, one per microcode step
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_MUL_SPAN  = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL_D100  = 5'd2;
    localparam logic [OP_W-1:0] OP_RATE      = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_PMS   = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL_RECIP = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_CHK   = 5'd6;
    localparam logic [OP_W-1:0] OP_INC       = 5'd7;
    localparam logic [OP_W-1:0] OP_ACC       = 5'd8;
    localparam logic [OP_W-1:0] OP_X100      = 5'd9;
    localparam logic [OP_W-1:0] OP_CLASS     = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL_RISE  = 5'd11;
    localparam logic [OP_W-1:0] OP_RISE_OUT  = 5'd12;
    localparam logic [OP_W-1:0] OP_MUL_LIN   = 5'd13;
    localparam logic [OP_W-1:0] OP_LIN_M     = 5'd14;
    localparam logic [OP_W-1:0] OP_MUL_LINR  = 5'd15;
    localparam logic [OP_W-1:0] OP_LIN_OUT   = 5'd16;
    localparam logic [OP_W-1:0] OP_HOLD_OUT  = 5'd17;
    localparam logic [OP_W-1:0] OP_MUL_SINE  = 5'd18;
    localparam logic [OP_W-1:0] OP_MUL_D62   = 5'd19;
    localparam logic [OP_W-1:0] OP_SINE_OUT  = 5'd20;
    localparam logic [OP_W-1:0] OP_DIS_OUT   = 5'd21;

    // curve segments
    localparam logic [SEG_W-1:0] SEG_RISE = 3'd0;
    localparam logic [SEG_W-1:0] SEG_FALL = 3'd1;
    localparam logic [SEG_W-1:0] SEG_HOLD = 3'd2;
    localparam logic [SEG_W-1:0] SEG_UP   = 3'd3;
    localparam logic [SEG_W-1:0] SEG_DOWN = 3'd4;
    localparam logic [SEG_W-1:0] SEG_REST = 3'd5;

    typedef struct packed {
        logic [7:0] min_bpm;
        logic [7:0] max_bpm;
        logic       enabled;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            accept;
        logic            load_out;
    } ctrl_t;

    typedef struct packed {
        logic             enabled;
        logic [SEG_W-1:0] seg;
    } stat_t;

endpackage

@@ sv/hpwg_useq.sv @@
// ============================================================================
// hpwg_useq
// Microcode sequencer: step counter, control store and branch logic.
// Also owns the input ready and the output valid of the beat handshakes.
// ============================================================================
module hpwg_useq import hpwg_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    localparam int UA_W = 5;

    localparam logic [2:0] SEQ_IDLE   = 3'd0;
    localparam logic [2:0] SEQ_NEXT   = 3'd1;
    localparam logic [2:0] SEQ_JUMP   = 3'd2;
    localparam logic [2:0] SEQ_IF_OFF = 3'd3;
    localparam logic [2:0] SEQ_SEG    = 3'd4;
    localparam logic [2:0] SEQ_DONE   = 3'd5;

    localparam logic [UA_W-1:0] UA_IDLE  = 5'd0;
    localparam logic [UA_W-1:0] UA_SPAN  = 5'd1;
    localparam logic [UA_W-1:0] UA_D100  = 5'd2;
    localparam logic [UA_W-1:0] UA_RATE  = 5'd3;
    localparam logic [UA_W-1:0] UA_PMS   = 5'd4;
    localparam logic [UA_W-1:0] UA_RECIP = 5'd5;
    localparam logic [UA_W-1:0] UA_CHK   = 5'd6;
    localparam logic [UA_W-1:0] UA_INC   = 5'd7;
    localparam logic [UA_W-1:0] UA_ACC   = 5'd8;
    localparam logic [UA_W-1:0] UA_X100  = 5'd9;
    localparam logic [UA_W-1:0] UA_CLASS = 5'd10;
    localparam logic [UA_W-1:0] UA_RISE  = 5'd11;
    localparam logic [UA_W-1:0] UA_RISE2 = 5'd12;
    localparam logic [UA_W-1:0] UA_LIN   = 5'd13;
    localparam logic [UA_W-1:0] UA_LIN2  = 5'd14;
    localparam logic [UA_W-1:0] UA_LIN3  = 5'd15;
    localparam logic [UA_W-1:0] UA_LIN4  = 5'd16;
    localparam logic [UA_W-1:0] UA_HOLD  = 5'd17;
    localparam logic [UA_W-1:0] UA_SINE  = 5'd18;
    localparam logic [UA_W-1:0] UA_SINE2 = 5'd19;
    localparam logic [UA_W-1:0] UA_SINE3 = 5'd20;
    localparam logic [UA_W-1:0] UA_DONE  = 5'd21;
    localparam logic [UA_W-1:0] UA_OFF   = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [2:0]      seq;
        logic [UA_W-1:0] target;
    } uword_t;

    function automatic uword_t uword(input logic [OP_W-1:0] op, input logic [2:0] seq,
                                     input logic [UA_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    // control store
    function automatic uword_t ucode(input logic [UA_W-1:0] addr);
        uword_t w;
        unique case (addr)
            UA_IDLE:  w = uword(OP_NOP,       SEQ_IDLE,   UA_IDLE);
            UA_SPAN:  w = uword(OP_MUL_SPAN,  SEQ_NEXT,   UA_IDLE);
            UA_D100:  w = uword(OP_MUL_D100,  SEQ_NEXT,   UA_IDLE);
            UA_RATE:  w = uword(OP_RATE,      SEQ_IF_OFF, UA_OFF);
            UA_PMS:   w = uword(OP_MUL_PMS,   SEQ_NEXT,   UA_IDLE);
            UA_RECIP: w = uword(OP_MUL_RECIP, SEQ_NEXT,   UA_IDLE);
            UA_CHK:   w = uword(OP_MUL_CHK,   SEQ_NEXT,   UA_IDLE);
            UA_INC:   w = uword(OP_INC,       SEQ_NEXT,   UA_IDLE);
            UA_ACC:   w = uword(OP_ACC,       SEQ_NEXT,   UA_IDLE);
            UA_X100:  w = uword(OP_X100,      SEQ_NEXT,   UA_IDLE);
            UA_CLASS: w = uword(OP_CLASS,     SEQ_SEG,    UA_IDLE);
            UA_RISE:  w = uword(OP_MUL_RISE,  SEQ_NEXT,   UA_IDLE);
            UA_RISE2: w = uword(OP_RISE_OUT,  SEQ_JUMP,   UA_DONE);
            UA_LIN:   w = uword(OP_MUL_LIN,   SEQ_NEXT,   UA_IDLE);
            UA_LIN2:  w = uword(OP_LIN_M,     SEQ_NEXT,   UA_IDLE);
            UA_LIN3:  w = uword(OP_MUL_LINR,  SEQ_NEXT,   UA_IDLE);
            UA_LIN4:  w = uword(OP_LIN_OUT,   SEQ_JUMP,   UA_DONE);
            UA_HOLD:  w = uword(OP_HOLD_OUT,  SEQ_JUMP,   UA_DONE);
            UA_SINE:  w = uword(OP_MUL_SINE,  SEQ_NEXT,   UA_IDLE);
            UA_SINE2: w = uword(OP_MUL_D62,   SEQ_NEXT,   UA_IDLE);
            UA_SINE3: w = uword(OP_SINE_OUT,  SEQ_NEXT,   UA_IDLE);
            UA_DONE:  w = uword(OP_NOP,       SEQ_DONE,   UA_IDLE);
            UA_OFF:   w = uword(OP_DIS_OUT,   SEQ_JUMP,   UA_DONE);
            default:  w = uword(OP_NOP,       SEQ_JUMP,   UA_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [UA_W-1:0] dispatch(input logic [SEG_W-1:0] seg);
        logic [UA_W-1:0] a;
        unique case (seg)
            SEG_RISE: a = UA_RISE;
            SEG_HOLD: a = UA_HOLD;
            SEG_REST: a = UA_SINE;
            default:  a = UA_LIN;
        endcase
        return a;
    endfunction

    logic [UA_W-1:0] ustep_reg, ustep_next;
    logic            m_valid_reg, m_valid_next;
    uword_t          uw;
    logic            accept;
    logic            out_free;
    logic            load_out;

    assign uw       = ucode(ustep_reg);
    assign s_ready  = (uw.seq == SEQ_IDLE);
    assign accept   = s_ready && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (uw.seq == SEQ_DONE) && out_free;

    always_comb begin
        unique case (uw.seq)
            SEQ_IDLE:   ustep_next = accept ? ustep_reg + 1'b1 : ustep_reg;
            SEQ_NEXT:   ustep_next = ustep_reg + 1'b1;
            SEQ_JUMP:   ustep_next = uw.target;
            SEQ_IF_OFF: ustep_next = stat.enabled ? ustep_reg + 1'b1 : uw.target;
            SEQ_SEG:    ustep_next = dispatch(stat.seg);
            SEQ_DONE:   ustep_next = out_free ? UA_IDLE : ustep_reg;
            default:    ustep_next = UA_IDLE;
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ustep_reg   <= UA_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            ustep_reg   <= ustep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign ctrl.op       = uw.op;
    assign ctrl.accept   = accept;
    assign ctrl.load_out = load_out;

endmodule

@@ sv/hpwg_datapath.sv @@
// ============================================================================
// hpwg_datapath
// Datapath of the heartbeat pulse generator: one shared multiplier with a
// product register, rate map, phase accumulator, curve evaluation, sine
// table and the output register.
// ============================================================================
module hpwg_datapath import hpwg_pkg::*; #(
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_t       ctrl,
    input  cfg_t        cfg,
    output stat_t       stat,
    input  logic [15:0] s_elapsed_ms,
    input  logic [7:0]  s_energy,
    output logic [7:0]  m_brightness,
    output logic        m_new_beat,
    output logic        m_beat_led,
    output logic [7:0]  m_beat_rate,
    output logic [23:0] m_phase_out
);

    localparam int PB     = PHASE_BITS;
    localparam int MUL_W  = (PHASE_BITS > 31) ? PHASE_BITS : 31;
    localparam int PROD_W = 2 * MUL_W;
    localparam int REM_W  = PHASE_BITS + 15;
    localparam int K_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int X_W    = 31;

    localparam longint unsigned INC_DIV   = 60000;
    localparam longint unsigned RECIP_INC = (64'd1 << (PHASE_BITS + 15)) / INC_DIV;
    localparam longint unsigned RECIP_100  = (64'd1 << 19) / 100 + 1;
    localparam longint unsigned RECIP_600  = (64'd1 << 32) / 600 + 1;
    localparam longint unsigned RECIP_1000 = (64'd1 << 32) / 1000 + 1;
    localparam longint unsigned RECIP_62   = (64'd1 << 20) / 62 + 1;

    localparam longint unsigned SCALE = 64'd1 << 24;
    localparam logic [X_W-1:0] X_8  = X_W'(8 * SCALE);
    localparam logic [X_W-1:0] X_18 = X_W'(18 * SCALE);
    localparam logic [X_W-1:0] X_22 = X_W'(22 * SCALE);
    localparam logic [X_W-1:0] X_28 = X_W'(28 * SCALE);
    localparam logic [X_W-1:0] X_38 = X_W'(38 * SCALE);

    localparam logic [28:0] RISE_2D   = 29'd1 << 28;
    localparam logic [62:0] RISE_HALF = 63'd1 << 53;

    localparam logic [6:0] SAT_MAX    = 7'd100;
    localparam logic [7:0] HOLD_LEVEL = 8'd77;
    localparam logic [7:0] IDLE_LEVEL = 8'd128;

    // sine breathing table, brightness per entry
    logic [7:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        localparam longint Q   = longint'(g) * longint'(SINE_TABLE_DEPTH - g);
        localparam longint DEN = 5 * longint'(SINE_TABLE_DEPTH) * longint'(SINE_TABLE_DEPTH)
                                 - 4 * Q;
        localparam longint SV  = (16 * Q * 65536 + DEN / 2) / DEN;
        localparam logic [7:0] LVL = 8'((255 * (15 * 65536 + 5 * SV) + 3276800) / 6553600);
        assign sine_rom[g] = LVL;
    end

    logic [6:0]        ms_reg, ms_next;
    logic [6:0]        en_reg, en_next;
    logic              neg_reg, neg_next;
    logic [7:0]        rate_reg, rate_next;
    logic [14:0]       pms_reg, pms_next;
    logic [PB-1:0]     q0_reg, q0_next;
    logic [PB-1:0]     inc_reg, inc_next;
    logic [PB-1:0]     acc_reg, acc_next;
    logic              beat_reg, beat_next;
    logic              led_reg, led_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [X_W-1:0]    v_reg, v_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [17:0]       m_reg, m_next;
    logic [7:0]        bright_reg, bright_next;
    logic [PROD_W-1:0] prod_reg;

    logic [7:0]  out_bright_reg;
    logic        out_beat_reg;
    logic        out_led_reg;
    logic [7:0]  out_rate_reg;
    logic [23:0] out_phase_reg;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              mul_en;
    logic [PROD_W-1:0] product;

    logic [8:0]       span_diff;
    logic             span_neg;
    logic [7:0]       span_mag;
    logic [PB+23:0]   p_shift;
    logic [23:0]      p24;
    logic [SEG_W-1:0] seg_cur;
    logic [X_W-1:0]   seg_base;
    logic [14:0]      lin_b;
    logic [19:0]      lin_c;
    logic [31:0]      lin_r;
    logic             lin_neg;
    logic [REM_W-1:0] rem;
    logic [PB:0]      sum;
    logic [62:0]      rise_y, rise_r;
    logic [42:0]      p_ceil;
    logic [17:0]      term;
    logic [19:0]      m_s;
    logic [8:0]       k_raw;
    logic [K_W-1:0]   k_idx;

    assign span_diff = {1'b0, cfg.max_bpm} - {1'b0, cfg.min_bpm};
    assign span_neg  = span_diff[8];
    assign span_mag  = span_neg ? 8'(-span_diff) : span_diff[7:0];

    assign p_shift = {acc_reg, 24'b0} >> PB;
    assign p24     = p_shift[23:0];

    always_comb begin
        priority if (x_reg < X_8) begin
            seg_cur = SEG_RISE;  seg_base = '0;
        end else if (x_reg < X_18) begin
            seg_cur = SEG_FALL;  seg_base = X_8;
        end else if (x_reg < X_22) begin
            seg_cur = SEG_HOLD;  seg_base = X_18;
        end else if (x_reg < X_28) begin
            seg_cur = SEG_UP;    seg_base = X_22;
        end else if (x_reg < X_38) begin
            seg_cur = SEG_DOWN;  seg_base = X_28;
        end else begin
            seg_cur = SEG_REST;  seg_base = X_38;
        end
    end

    assign stat.enabled = cfg.enabled;
    assign stat.seg     = seg_cur;

    // per-segment constants of the linear pieces, 255 folded in
    always_comb begin
        unique case (seg_reg)
            SEG_FALL: begin
                lin_b = 15'd17850;  lin_c = 20'd255500;
                lin_r = 32'(RECIP_1000);  lin_neg = 1'b1;
            end
            SEG_UP: begin
                lin_b = 15'd7650;   lin_c = 20'd46200;
                lin_r = 32'(RECIP_600);   lin_neg = 1'b0;
            end
            default: begin
                lin_b = 15'd11475;  lin_c = 20'd153500;
                lin_r = 32'(RECIP_1000);  lin_neg = 1'b1;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (ctrl.op)
            OP_MUL_SPAN: begin
                mul_a = MUL_W'(en_reg);
                mul_b = MUL_W'(span_mag);
            end
            OP_MUL_D100: begin
                mul_a = MUL_W'(prod_reg[14:0]);
                mul_b = MUL_W'(RECIP_100);
            end
            OP_MUL_PMS: begin
                mul_a = MUL_W'(rate_reg);
                mul_b = MUL_W'(ms_reg);
            end
            OP_MUL_RECIP: begin
                mul_a = MUL_W'(prod_reg[14:0]);
                mul_b = MUL_W'(RECIP_INC);
            end
            OP_MUL_CHK: begin
                mul_a = MUL_W'(prod_reg[15 +: PB]);
                mul_b = MUL_W'(INC_DIV);
            end
            OP_MUL_RISE: begin
                mul_a = MUL_W'(x_reg[26:0]);
                mul_b = MUL_W'(RISE_2D - {2'b00, x_reg[26:0]});
            end
            OP_MUL_LIN: begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(lin_b);
            end
            OP_MUL_LINR: begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(lin_r);
            end
            OP_MUL_SINE: begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(SINE_TABLE_DEPTH);
            end
            OP_MUL_D62: begin
                mul_a = MUL_W'(prod_reg[39:24]);
                mul_b = MUL_W'(RECIP_62);
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign rem    = {pms_reg, {PB{1'b0}}} - prod_reg[REM_W-1:0];
    assign sum    = {1'b0, acc_reg} + {1'b0, inc_reg};
    assign rise_y = 63'(prod_reg[54:0]);
    assign rise_r = (rise_y << 8) - rise_y + RISE_HALF;
    // negative slope: floor of a negative term is minus the ceiling
    assign p_ceil = {1'b0, prod_reg[41:0]} + 43'(SCALE - 1);
    assign term   = lin_neg ? p_ceil[41:24] : prod_reg[41:24];
    assign m_s    = lin_neg ? lin_c - 20'(term) : lin_c + 20'(term);
    assign k_raw  = prod_reg[28:20];
    assign k_idx  = (k_raw > 9'(SINE_TABLE_DEPTH - 1)) ? K_W'(SINE_TABLE_DEPTH - 1)
                                                       : k_raw[K_W-1:0];

    always_comb begin
        ms_next     = ms_reg;
        en_next     = en_reg;
        neg_next    = neg_reg;
        rate_next   = rate_reg;
        pms_next    = pms_reg;
        q0_next     = q0_reg;
        inc_next    = inc_reg;
        acc_next    = acc_reg;
        beat_next   = beat_reg;
        led_next    = led_reg;
        x_next      = x_reg;
        v_next      = v_reg;
        seg_next    = seg_reg;
        m_next      = m_reg;
        bright_next = bright_reg;
        if (ctrl.accept) begin
            ms_next = (s_elapsed_ms > 16'(SAT_MAX)) ? SAT_MAX : s_elapsed_ms[6:0];
            en_next = (s_energy > 8'(SAT_MAX)) ? SAT_MAX : s_energy[6:0];
        end
        unique case (ctrl.op)
            OP_MUL_SPAN:  neg_next = span_neg;
            OP_RATE:      rate_next = neg_reg ? cfg.min_bpm - prod_reg[26:19]
                                              : cfg.min_bpm + prod_reg[26:19];
            OP_MUL_RECIP: pms_next = prod_reg[14:0];
            OP_MUL_CHK:   q0_next = prod_reg[15 +: PB];
            OP_INC:       inc_next = q0_reg + PB'(rem >= REM_W'(INC_DIV));
            OP_ACC: begin
                acc_next  = sum[PB-1:0];
                beat_next = sum[PB];
                led_next  = led_reg ^ sum[PB];
            end
            OP_X100:      x_next = (X_W'(p24) << 6) + (X_W'(p24) << 5) + (X_W'(p24) << 2);
            OP_CLASS: begin
                seg_next = seg_cur;
                v_next   = x_reg - seg_base;
            end
            OP_RISE_OUT:  bright_next = rise_r[61:54];
            OP_LIN_M:     m_next = m_s[19] ? '0 : m_s[17:0];
            OP_LIN_OUT:   bright_next = prod_reg[39:32];
            OP_HOLD_OUT:  bright_next = HOLD_LEVEL;
            OP_SINE_OUT:  bright_next = sine_rom[k_idx];
            OP_DIS_OUT: begin
                bright_next = IDLE_LEVEL;
                beat_next   = 1'b0;
                led_next    = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            led_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            led_reg <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        ms_reg     <= ms_next;
        en_reg     <= en_next;
        neg_reg    <= neg_next;
        rate_reg   <= rate_next;
        pms_reg    <= pms_next;
        q0_reg     <= q0_next;
        inc_reg    <= inc_next;
        beat_reg   <= beat_next;
        x_reg      <= x_next;
        v_reg      <= v_next;
        seg_reg    <= seg_next;
        m_reg      <= m_next;
        bright_reg <= bright_next;
        if (mul_en) begin
            prod_reg <= product;
        end
        if (ctrl.load_out) begin
            out_bright_reg <= bright_reg;
            out_beat_reg   <= beat_reg;
            out_led_reg    <= led_reg;
            out_rate_reg   <= rate_reg;
            out_phase_reg  <= p24;
        end
    end

    assign m_brightness = out_bright_reg;
    assign m_new_beat   = out_beat_reg;
    assign m_beat_led   = out_led_reg;
    assign m_beat_rate  = out_rate_reg;
    assign m_phase_out  = out_phase_reg;

endmodule

@@ sv/heartbeat_pulse_waveform_generator.sv @@
// ============================================================================
// heartbeat_pulse_waveform_generator
// One beat in on the s_ channel (elapsed ms, energy) gives one beat out on the
// m_ channel (brightness, new_beat, LED level, rate, phase). A microcoded
// sequencer steps a datapath built around one shared multiplier, so each
// beat runs as a sequence of microcode steps from acceptance to a loaded
// result (hold segment shortest, linear segments longest when running, and
// shorter still when disabled). The result sits in an output register and
// the next beat is accepted while it waits; a result still unread when the
// following one is ready stalls the sequencer.
// Configuration writes are taken at any time and must only be made while
// the block is idle.
// ============================================================================
module heartbeat_pulse_waveform_generator import hpwg_pkg::*; #(
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_elapsed_ms,
    input  logic [7:0]  s_energy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_brightness,
    output logic        m_new_beat,
    output logic        m_beat_led,
    output logic [7:0]  m_beat_rate,
    output logic [23:0] m_phase_out,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam logic [1:0] CFG_MIN_BPM = 2'd0;
    localparam logic [1:0] CFG_MAX_BPM = 2'd1;
    localparam logic [1:0] CFG_ENABLED = 2'd2;

    logic [7:0] min_bpm_reg;
    logic [7:0] max_bpm_reg;
    logic       enabled_reg;
    cfg_t       cfg;
    ctrl_t      ctrl;
    stat_t      stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_bpm_reg <= 8'd60;
            max_bpm_reg <= 8'd120;
            enabled_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MIN_BPM: min_bpm_reg <= cfg_wdata;
                CFG_MAX_BPM: max_bpm_reg <= cfg_wdata;
                CFG_ENABLED: enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg.min_bpm = min_bpm_reg;
    assign cfg.max_bpm = max_bpm_reg;
    assign cfg.enabled = enabled_reg;

    hpwg_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    hpwg_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .stat         (stat),
        .s_elapsed_ms (s_elapsed_ms),
        .s_energy     (s_energy),
        .m_brightness (m_brightness),
        .m_new_beat   (m_new_beat),
        .m_beat_led   (m_beat_led),
        .m_beat_rate  (m_beat_rate),
        .m_phase_out  (m_phase_out)
    );

endmodule

@@ dv/hpwg_tb_pkg.sv @@
`timescale 1ns / 100ps
// ============================================================================
// hpwg_tb_pkg
// Register indexes of the heartbeat generator's write port, shared by the
// stimulus and the checker.
// ============================================================================
package hpwg_tb_pkg;

    localparam logic [1:0] REG_MIN_BPM = 2'd0;
    localparam logic [1:0] REG_MAX_BPM = 2'd1;
    localparam logic [1:0] REG_ENABLED = 2'd2;
    localparam logic [1:0] REG_SPARE   = 2'd3;

endpackage

@@ dv/hpwg_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// hpwg_checker
// Watches the tick and result channels and the register write port, keeps a
// shadow of the rate map, phase accumulator and LED, predicts one pulse per
// accepted tick and compares each result beat field by field in order.
// ============================================================================
module hpwg_checker import hpwg_tb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_elapsed_ms,
    input  logic [7:0]  s_energy,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_brightness,
    input  logic        m_new_beat,
    input  logic        m_beat_led,
    input  logic [7:0]  m_beat_rate,
    input  logic [23:0] m_phase_out,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          pending
);

    localparam longint SCALE      = 64'sd16777216;
    localparam longint SINE_DEPTH = 64;

    typedef struct packed {
        logic [7:0]  brightness;
        logic        new_beat;
        logic        beat_led;
        logic [7:0]  beat_rate;
        logic [23:0] phase_out;
    } pulse_t;

    pulse_t      pulse_q[$];
    logic [7:0]  min_bpm;
    logic [7:0]  max_bpm;
    logic        run_en;
    logic [23:0] phase;
    logic        led;
    int          errs;
    int          backlog;

    assign fail_count = errs;
    assign pending    = backlog;

    function automatic logic [7:0] ramp_level(input longint a, input longint b,
                                              input longint w, input longint v);
        longint num;
        longint den;
        num = a * w * SCALE + b * v;
        den = 100 * w * SCALE;
        if (num < 0) num = 0;
        return 8'((255 * num + den / 2) / den);
    endfunction

    function automatic longint sine_entry(input longint k);
        longint q;
        longint den;
        q   = k * (SINE_DEPTH - k);
        den = 5 * SINE_DEPTH * SINE_DEPTH - 4 * q;
        return (16 * q * 65536 + den / 2) / den;
    endfunction

    // lub-dub curve: quadratic rise, four linear pieces, sine-table rest
    function automatic logic [7:0] curve_level(input logic [23:0] p);
        longint          x;
        longint          k;
        longint          num;
        longint unsigned u;
        longint unsigned prod;
        x = longint'(p) * 100;
        if (x < 8 * SCALE) begin
            u    = x;
            prod = 64'd255 * u * (64'd268435456 - u);
            return 8'((prod + (64'd1 << 53)) >> 54);
        end
        if (x < 18 * SCALE) return ramp_level(100, -70, 10, x - 8 * SCALE);
        if (x < 22 * SCALE) return ramp_level(30, 0, 1, 0);
        if (x < 28 * SCALE) return ramp_level(30, 30, 6, x - 22 * SCALE);
        if (x < 38 * SCALE) return ramp_level(60, -45, 10, x - 28 * SCALE);
        k = ((x - 38 * SCALE) * SINE_DEPTH) / (62 * SCALE);
        if (k > SINE_DEPTH - 1) k = SINE_DEPTH - 1;
        num = 255 * (15 * 65536 + 5 * sine_entry(k));
        return 8'((num + 3276800) / 6553600);
    endfunction

    function automatic pulse_t advance_heartbeat(input logic [15:0] ms_in,
                                                 input logic [7:0]  en_in);
        pulse_t          res;
        logic [15:0]     ms;
        logic [7:0]      en;
        int              span;
        int              rate;
        longint unsigned inc;
        longint unsigned sum;
        ms   = (ms_in > 16'd100) ? 16'd100 : ms_in;
        en   = (en_in > 8'd100) ? 8'd100 : en_in;
        span = int'(max_bpm) - int'(min_bpm);
        rate = int'(min_bpm) + (int'(en) * span) / 100;
        res.beat_rate = rate[7:0];
        res.new_beat  = 1'b0;
        if (run_en) begin
            inc = ((64'(res.beat_rate) * 64'(ms)) << 24) / 60000;
            sum = 64'(phase) + inc;
            if (sum >= (64'd1 << 24)) begin
                sum          = sum - (64'd1 << 24);
                res.new_beat = 1'b1;
            end
            phase = sum[23:0];
            if (res.new_beat) led = ~led;
            res.brightness = curve_level(phase);
        end else begin
            led            = 1'b0;
            res.brightness = 8'd128;
        end
        res.beat_led  = led;
        res.phase_out = phase;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        pulse_t want;
        if (!aresetn) begin
            pulse_q.delete();
            min_bpm = 8'd60;
            max_bpm = 8'd120;
            run_en  = 1'b1;
            phase   = '0;
            led     = 1'b0;
            errs    = 0;
            backlog <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_BPM: min_bpm = cfg_wdata;
                    REG_MAX_BPM: max_bpm = cfg_wdata;
                    REG_ENABLED: run_en  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pulse_q.size() == 0) begin
                    $error("result beat with no tick pending");
                    errs++;
                end else begin
                    want = pulse_q.pop_front();
                    check_field("brightness", 24'(want.brightness), 24'(m_brightness));
                    check_field("new_beat", 24'(want.new_beat), 24'(m_new_beat));
                    check_field("beat_led", 24'(want.beat_led), 24'(m_beat_led));
                    check_field("beat_rate", 24'(want.beat_rate), 24'(m_beat_rate));
                    check_field("phase_out", want.phase_out, m_phase_out);
                end
            end
            if (s_valid && s_ready)
                pulse_q.push_back(advance_heartbeat(s_elapsed_ms, s_energy));
            backlog <= pulse_q.size();
        end
    end

endmodule

@@ dv/tb_heartbeat_pulse_waveform_generator.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_heartbeat_pulse_waveform_generator
// Drives ticks through the heartbeat generator under random idle and stall,
// walks the curve through full beats, covers saturation, disable, inverted
// and extreme rate maps, then runs random phases under random settings. The
// checker beside the block predicts and compares every result beat.
// ============================================================================
module tb_heartbeat_pulse_waveform_generator;
    import hpwg_tb_pkg::*;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_elapsed_ms = '0;
    logic [7:0]  s_energy     = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_brightness;
    logic        m_new_beat;
    logic        m_beat_led;
    logic [7:0]  m_beat_rate;
    logic [23:0] m_phase_out;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_index    = '0;
    logic [7:0]  cfg_wdata    = '0;

    int fail_count;
    int pending;
    int ticks_sent = 0;
    bit gaps_on    = 1'b1;

    heartbeat_pulse_waveform_generator u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elapsed_ms (s_elapsed_ms),
        .s_energy     (s_energy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_brightness (m_brightness),
        .m_new_beat   (m_new_beat),
        .m_beat_led   (m_beat_led),
        .m_beat_rate  (m_beat_rate),
        .m_phase_out  (m_phase_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    hpwg_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elapsed_ms (s_elapsed_ms),
        .s_energy     (s_energy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_brightness (m_brightness),
        .m_new_beat   (m_new_beat),
        .m_beat_led   (m_beat_led),
        .m_beat_rate  (m_beat_rate),
        .m_phase_out  (m_phase_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= 32);
    end

    task automatic send_tick(input logic [15:0] ms, input logic [7:0] en);
        if (gaps_on) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_elapsed_ms <= ms;
        s_energy     <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic send_random_tick();
        logic [15:0] ms;
        logic [7:0]  en;
        ms = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(100));
        en = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(100));
        send_tick(ms, en);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [7:0] lo_bpm;
        logic [7:0] hi_bpm;
        int         n_ticks;
        int         phase_no;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset map 60..120: extremes, saturation, then a full walk of the curve
        send_tick(16'd0, 8'd0);
        send_tick(16'd65535, 8'd255);
        send_tick(16'd100, 8'd100);
        send_tick(16'd101, 8'd101);
        send_tick(16'd100, 8'd0);
        repeat (20) send_tick(16'd25, 8'd100);
        wait_drained();

        // disabled: frozen phase, neutral brightness, LED off
        cfg_write(REG_ENABLED, {7'($urandom_range(127)), 1'b0});
        send_tick(16'd100, 8'd100);
        send_tick(16'd65535, 8'd255);
        send_tick(16'd7, 8'd33);
        wait_drained();
        cfg_write(REG_ENABLED, {7'($urandom_range(127)), 1'b1});
        cfg_write(REG_SPARE, 8'hFF);

        // extreme and inverted rate maps
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: begin lo_bpm = 8'd0;   hi_bpm = 8'd0;   end
                1: begin lo_bpm = 8'd255; hi_bpm = 8'd255; end
                2: begin lo_bpm = 8'd255; hi_bpm = 8'd0;   end
                default: begin lo_bpm = 8'd0; hi_bpm = 8'd255; end
            endcase
            cfg_write(REG_MIN_BPM, lo_bpm);
            cfg_write(REG_MAX_BPM, hi_bpm);
            repeat (30) send_random_tick();
            wait_drained();
        end

        phase_no = 0;
        while (ticks_sent < 1400) begin
            lo_bpm = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                              : 8'($urandom_range(255));
            hi_bpm = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                              : 8'($urandom_range(255));
            cfg_write(REG_MIN_BPM, lo_bpm);
            cfg_write(REG_MAX_BPM, hi_bpm);
            cfg_write(REG_ENABLED,
                      {7'($urandom_range(127)), 1'($urandom_range(99) >= 15)});
            if ($urandom_range(3) == 0) cfg_write(REG_SPARE, 8'($urandom_range(255)));
            gaps_on = (phase_no != 3);
            n_ticks = $urandom_range(60, 160);
            for (int t = 0; t < n_ticks; t++) begin
                if (phase_no == 2 && t == n_ticks / 2) wait_drained();
                send_random_tick();
            end
            wait_drained();
            phase_no++;
        end
        gaps_on = 1'b1;

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("** heartbeat_pulse_waveform_generator: PASSED **");
        else
            $display("** heartbeat_pulse_waveform_generator: FAILED **");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** heartbeat_pulse_waveform_generator: FAILED **");
        $finish;
    end

endmodule
